FILE: design/udasc_pkg.sv
// ----------------------------------------------------------------------------
// udasc_pkg : shared types and constants for the decimal ASCII converter
// Holds the digit count, the BCD cell control bundle and the state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package udasc_pkg;

    localparam int MAX_WIDTH_DEF = 16;   // default widest padded field
    localparam int VALUE_W       = 32;   // binary input width
    localparam int NUM_DIGITS    = 10;   // decimal digits of a 32-bit value
    localparam int BCD_W         = 4;
    localparam int BIT_CNT_W     = $clog2(VALUE_W);
    localparam int COUNT_W       = $clog2(NUM_DIGITS + 1);
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } udasc_state_t;

    // control bundle broadcast to every BCD cell
    typedef struct packed {
        logic clear;   // load a fresh conversion
        logic shift;   // take one binary bit in
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/udasc_cell.sv
// ----------------------------------------------------------------------------
// udasc_cell : one BCD digit cell of the shift-and-add-3 chain
// Corrects the digit when it is five or more, then shifts in the carry
// from the lower neighbour and passes its top bit to the upper one.
// ----------------------------------------------------------------------------
`default_nettype none

module udasc_cell
    import udasc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic              carry_in,
    output logic                   carry_out,
    output logic [BCD_W-1:0]       digit
);

    logic [BCD_W-1:0] digit_reg;
    logic [BCD_W-1:0] digit_next;
    logic [BCD_W-1:0] adjusted;

    always_comb
    begin
        adjusted = (digit_reg >= BCD_W'(5)) ? digit_reg + BCD_W'(3) : digit_reg;
        if (ctrl.clear)
            digit_next = '0;
        else if (ctrl.shift)
            digit_next = {adjusted[BCD_W-2:0], carry_in};
        else
            digit_next = digit_reg;
    end

    assign carry_out = adjusted[BCD_W-1];
    assign digit     = digit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digit_reg <= '0;
        else
            digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

FILE: design/unsigned_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii : 32-bit unsigned to decimal ASCII text
// Converts one request into its decimal characters, optionally right-justified
// with a fill character, through a row of ten BCD cells.
// ----------------------------------------------------------------------------
// Conversion: bit-serial through the BCD cell row (ST_CONV), then the field is
//   sized (ST_SIZE), then the first character appears.
// Requests: a new request is taken only after the last character of the previous one,
//   set by the single shared cell row and the one-character output port.
// Reset: rst_n clears the controller and the cells; the block comes up idle.
`default_nettype none

module unsigned_to_decimal_ascii
    import udasc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // [31:0] value, [36:32] width, [44:37] fill_char
    input  wire logic        s_tuser,  // [0] mode
    // character stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // [7:0] character
    output logic             m_tlast,  // last character of the conversion
    output logic             m_tuser   // [0] error
);

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam logic [PW-1:0] MAXW = PW'(MAX_WIDTH);

    udasc_state_t state_reg, state_next;

    logic                 mode_reg,  mode_next;
    logic [4:0]           width_reg, width_next;
    logic [7:0]           fill_reg,  fill_next;
    logic [VALUE_W-1:0]   shift_reg, shift_next;
    logic [BIT_CNT_W-1:0] bit_reg,   bit_next;
    logic [PW-1:0]        pos_reg,   pos_next;
    logic [PW-1:0]        total_reg, total_next;
    logic [PW-1:0]        pad_reg,   pad_next;
    logic                 err_reg,   err_next;

    cell_ctrl_t           cell_ctrl;
    logic [NUM_DIGITS:0]  carry;
    logic [BCD_W-1:0]     digit [NUM_DIGITS];

    logic                 s_fire;
    logic                 m_fire;
    logic                 at_end;
    logic [COUNT_W-1:0]   count;
    logic [PW-1:0]        sat_width;
    logic [PW-1:0]        dig_idx;
    logic [BCD_W-1:0]     dig_sel;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign at_end = err_reg || (pos_reg == total_reg - PW'(1));

    // ---------------------------------------------------------------- cell row
    // cell 0 takes the binary word MSB first; each cell feeds the next one up
    assign carry[0] = shift_reg[VALUE_W-1];

    for (genvar g = 0; g < NUM_DIGITS; g++)
    begin : g_cell
        udasc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .carry_in  (carry[g]),
            .carry_out (carry[g+1]),
            .digit     (digit[g])
        );
    end

    // ------------------------------------------------------------ field sizing
    // digit count: position of the highest non-zero digit, at least one
    always_comb
    begin
        count = COUNT_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (digit[i] != '0)
                count = COUNT_W'(i + 1);
        end
    end

    // clamp the requested width to the widest field
    assign sat_width = (32'(width_reg) > 32'(MAX_WIDTH)) ? MAXW : PW'(width_reg);

    // ---------------------------------------------------------- character pick
    // digits run from index total-1 down to zero as the position advances
    assign dig_idx = total_reg - pos_reg - PW'(1);

    always_comb
    begin
        dig_sel = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (dig_idx == PW'(i))
                dig_sel = digit[i];
        end
    end

    always_comb
    begin
        if (err_reg)
            m_tdata = 8'h00;
        else if (pos_reg < pad_reg)
            m_tdata = fill_reg;
        else
            m_tdata = ASCII_ZERO + {4'h0, dig_sel};
    end

    assign m_tlast = at_end;
    assign m_tuser = err_reg;

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (bit_reg == BIT_CNT_W'(VALUE_W - 1))
                    state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_fire && at_end)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb
    begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.shift = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // ready is held high here, so a valid request is taken now
                s_tready        = 1'b1;
                cell_ctrl.clear = s_tvalid;
            end
            ST_CONV:
            begin
                cell_ctrl.shift = 1'b1;
            end
            ST_SIZE:
            begin
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // -------------------------------------------------------- datapath update
    always_comb
    begin
        mode_next  = mode_reg;
        width_next = width_reg;
        fill_next  = fill_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;

        if (s_fire)
        begin
            // latch the request and restart the bit counter
            shift_next = s_tdata[31:0];
            width_next = s_tdata[36:32];
            fill_next  = s_tdata[44:37];
            mode_next  = s_tuser;
            bit_next   = '0;
        end

        if (cell_ctrl.shift)
        begin
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            bit_next   = bit_reg + BIT_CNT_W'(1);
        end

        if (state_reg == ST_SIZE)
        begin
            pos_next = '0;
            if (!mode_reg)
            begin
                total_next = PW'(count);
                pad_next   = '0;
                err_next   = 1'b0;
            end
            else if (sat_width < PW'(count))
            begin
                // field too narrow: one flagged result, no characters
                total_next = PW'(1);
                pad_next   = '0;
                err_next   = 1'b1;
            end
            else
            begin
                total_next = sat_width;
                pad_next   = sat_width - PW'(count);
                err_next   = 1'b0;
            end
        end

        if (m_fire)
            pos_next = pos_reg + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        width_reg <= width_next;
        fill_reg  <= fill_next;
        shift_reg <= shift_next;
        total_reg <= total_next;
        pad_reg   <= pad_next;
    end

`ifndef ASSERT_OFF
    // a flagged result is always the only one of its conversion
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error result without last");

    // no new request is taken while one is in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("request accepted while busy");

    // the output closes after the last character is taken
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && m_tlast) |=> !m_tvalid)
        else $error("output still valid after last");

    // the emit position never runs past the field
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pos_reg < total_reg))
        else $error("character position beyond field");
`endif

endmodule

`default_nettype wire
